### hdl/assert_macros.svh
// Assertion macros shared by the sprite chain position step RTL.
// Assertions compile unless SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SCPS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define SCPS_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define SCPS_ASSERT(lbl, clk, rst, prop)

`define SCPS_NEVER(lbl, clk, rst, cond)

`endif

`endif

### hdl/scps_pkg.sv
// Types and constants for the sprite chain position step unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package scps_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int STICKY_BIT = 6;
  localparam logic [13:0] NARROW_SHIFT = 14'd8;
  localparam logic signed [13:0] X_WRAP_AT = 14'sd480;
  localparam logic signed [13:0] X_WRAP = 14'sd512;
  localparam logic signed [14:0] WIDTH_WIDE = 15'sd320;
  localparam logic signed [14:0] WIDTH_NARROW = 15'sd304;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_FULL = 2'd1,
    MODE_CLIP = 2'd2
  } render_mode_t;

  // Decoded bank word handed from front to back.
  typedef struct packed {
    logic [8:0]         bank;
    logic               sticky;
    logic               narrow;
    logic signed [13:0] nx;
    logic [8:0]         y;
    logic [7:0]         y_zoom;
    logic [5:0]         size;
    logic [3:0]         x_zoom;
  } scps_item_t;

endpackage

### hdl/scps_front.sv
// Front stage: accepts attribute words and decodes them into an item.
// Depends on scps_pkg.
`timescale 1ns / 1ps

module scps_front
  import scps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        narrow_screen,
  input  logic        push,
  output logic        full,
  input  logic [8:0]  bank_index,
  input  logic [15:0] attr_zoom,
  input  logic [15:0] attr_y_chain_size,
  input  logic [15:0] attr_x,
  output logic        item_valid,
  input  logic        item_ready,
  output scps_item_t  item
);

  logic       take;
  scps_item_t decoded;
  logic [13:0] x_raw;

  assign full = item_valid && !item_ready;
  assign take = push && !full;

  always_comb begin
    x_raw = {5'd0, attr_x[15:7]};
    decoded.bank   = bank_index;
    decoded.sticky = attr_y_chain_size[STICKY_BIT];
    decoded.narrow = narrow_screen;
    decoded.nx     = narrow_screen ? $signed(x_raw - NARROW_SHIFT) : $signed(x_raw);
    decoded.y      = 9'd0 - attr_y_chain_size[15:7];
    decoded.y_zoom = attr_zoom[7:0];
    decoded.size   = attr_y_chain_size[5:0];
    decoded.x_zoom = attr_zoom[11:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= decoded;
    end
  end

endmodule

### hdl/scps_queue.sv
// Short queue of decoded items between the front and back stages.
// Depends on scps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scps_queue
  import scps_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  scps_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output scps_item_t out_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scps_item_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          wr;
  logic          rd;

  assign in_ready  = count != CW'(DEPTH);
  assign out_valid = count != '0;
  assign out_item  = slots[rd_ptr];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= in_item;
    end
  end

  `SCPS_NEVER(a_queue_overfill, clk, rst, count > CW'(DEPTH))
  `SCPS_ASSERT(a_queue_fill_step, clk, rst, (wr && !rd) |=> (count == $past(count) + 1'b1))

endmodule

### hdl/scps_back.sv
// Back stage: chains or loads the bank position, wraps X and classifies the draw.
// Holds the running position state and the result register. Depends on scps_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scps_back
  import scps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  scps_item_t  item,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  render_mode,
  output logic [8:0]  out_bank_index,
  output logic signed [9:0] x_position,
  output logic [8:0]  y_position,
  output logic [3:0]  x_zoom,
  output logic [7:0]  y_zoom,
  output logic [5:0]  bank_size
);

  logic signed [13:0] cur_x;
  logic [8:0]         cur_y;
  logic [3:0]         cur_x_zoom;
  logic [7:0]         cur_y_zoom;
  logic [5:0]         cur_size;
  logic               out_valid;

  logic               take;
  logic signed [13:0] x_chain;
  logic signed [13:0] x_sel;
  logic signed [13:0] x_next;
  logic [8:0]         y_use;
  logic [7:0]         yz_use;
  logic [5:0]         size_use;
  logic [3:0]         xz_use;
  logic signed [14:0] x_ext;
  logic signed [14:0] xz_ext;
  logic signed [14:0] width;
  render_mode_t       mode;

  assign empty      = !out_valid;
  assign item_ready = !out_valid || pop;
  assign take       = item_valid && item_ready;

  always_comb begin
    x_chain  = cur_x + $signed({10'd0, cur_x_zoom}) + 14'sd1;
    x_sel    = item.sticky ? x_chain : item.nx;
    size_use = item.sticky ? cur_size : item.size;
    y_use    = item.sticky ? cur_y : item.y;
    yz_use   = item.sticky ? cur_y_zoom : item.y_zoom;
    xz_use   = (size_use != '0) ? item.x_zoom : cur_x_zoom;
    x_next   = ((size_use != '0) && (x_sel >= X_WRAP_AT)) ? x_sel - X_WRAP : x_sel;
    x_ext    = {x_next[13], x_next};
    xz_ext   = $signed({11'd0, xz_use});
    width    = item.narrow ? WIDTH_NARROW : WIDTH_WIDE;
    mode     = MODE_NONE;
    if (size_use != '0) begin
      if (x_ext >= 15'sd0 && x_ext < width - xz_ext - 15'sd1) begin
        mode = MODE_FULL;
      end else if (x_ext >= -xz_ext && x_ext < width) begin
        mode = MODE_CLIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      cur_x_zoom <= '0;
      cur_y_zoom <= '0;
      cur_size   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        cur_x      <= x_next;
        cur_y      <= y_use;
        cur_x_zoom <= xz_use;
        cur_y_zoom <= yz_use;
        cur_size   <= size_use;
        out_valid  <= 1'b1;
      end else if (pop) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      render_mode    <= mode;
      out_bank_index <= item.bank;
      x_position     <= (mode == MODE_NONE) ? 10'sd0 : x_next[9:0];
      y_position     <= y_use;
      x_zoom         <= xz_use;
      y_zoom         <= yz_use;
      bank_size      <= size_use;
    end
  end

  `SCPS_NEVER(a_mode_needs_size, clk, rst,
    out_valid && (render_mode != MODE_NONE) && (bank_size == '0))
  `SCPS_NEVER(a_hidden_x_zero, clk, rst,
    out_valid && (render_mode == MODE_NONE) && (x_position != '0))
  `SCPS_ASSERT(a_take_shows_word, clk, rst, take |=> out_valid)

endmodule

### hdl/sprite_chain_position_step_unit.sv
// Sprite chain position step unit: top level.
// Holds the screen width register and joins front, queue and back.
// Depends on scps_pkg, scps_front, scps_queue and scps_back.
//
// Usage:
//   Input channel: drive bank_index and the three attribute words with push;
//   a word is taken at a clock edge with push high and full low.
//   Result channel: while empty is low the oldest result is on render_mode,
//   out_bank_index, x_position, y_position, x_zoom, y_zoom and bank_size;
//   pop high at a clock edge with empty low takes it.
//   Config: narrow_screen_wr_en writes narrow_screen_wr_data[0] into the
//   screen width register; write only while the block holds no words.
//   Path: front register, then queue slot, then result register.
//   Throughput: one word per cycle while pop takes each result, set by the
//   combinational chain add, wrap and classify in the back stage.
//   Stall: when pop stays low the result register holds, the queue fills,
//   then full rises; no word is lost.
//   Reset (rst, synchronous): clears the position state, the queue and the
//   screen width register; no clearing pass is needed.
`timescale 1ns / 1ps

module sprite_chain_position_step_unit
  import scps_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        narrow_screen_wr_en,
  input  logic        narrow_screen_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [8:0]  bank_index,
  input  logic [15:0] attr_zoom,
  input  logic [15:0] attr_y_chain_size,
  input  logic [15:0] attr_x,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  render_mode,
  output logic [8:0]  out_bank_index,
  output logic signed [9:0] x_position,
  output logic [8:0]  y_position,
  output logic [3:0]  x_zoom,
  output logic [7:0]  y_zoom,
  output logic [5:0]  bank_size
);

  logic       narrow_screen;
  logic       f_valid;
  logic       f_ready;
  scps_item_t f_item;
  logic       b_valid;
  logic       b_ready;
  scps_item_t b_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_screen <= 1'b0;
    end else if (narrow_screen_wr_en) begin
      narrow_screen <= narrow_screen_wr_data;
    end
  end

  scps_front u_front (
    .clk               (clk),
    .rst               (rst),
    .narrow_screen     (narrow_screen),
    .push              (push),
    .full              (full),
    .bank_index        (bank_index),
    .attr_zoom         (attr_zoom),
    .attr_y_chain_size (attr_y_chain_size),
    .attr_x            (attr_x),
    .item_valid        (f_valid),
    .item_ready        (f_ready),
    .item              (f_item)
  );

  scps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  scps_back u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (b_valid),
    .item_ready     (b_ready),
    .item           (b_item),
    .empty          (empty),
    .pop            (pop),
    .render_mode    (render_mode),
    .out_bank_index (out_bank_index),
    .x_position     (x_position),
    .y_position     (y_position),
    .x_zoom         (x_zoom),
    .y_zoom         (y_zoom),
    .bank_size      (bank_size)
  );

endmodule
